### design/ryln_pkg.sv
// ============================================================================
// RGB/YIQ luma noise package
// Fixed-point formats, coefficients and the output saturation function for
// the RGB to YIQ to RGB pixel path with luma noise injection.
// ============================================================================
package ryln_pkg;

    // Fractional bits of every coefficient (signed Q2.F, magnitudes only).
    localparam int COEF_FRAC_BITS = 12;
    localparam int ONE_Q          = 1 << COEF_FRAC_BITS;

    localparam int CH_W    = 8;   // one color channel
    localparam int NOISE_W = 11;  // signed noise sample in thousandths
    localparam int LEVEL_W = 9;   // noise level, Q1.8

    // Configuration address map.
    localparam int          PADDR_W          = 3;
    localparam logic [2:0]  ADDR_NOISE_LEVEL = 3'd0;

    // Round a coefficient in thousandths to Q2.F, half up.
    function automatic int kq(input int milli);
        return (milli * ONE_Q + 500) / 1000;
    endfunction

    localparam int K_YR = kq(299);
    localparam int K_YG = kq(587);
    localparam int K_YB = kq(114);
    localparam int K_IR = kq(596);
    localparam int K_IG = kq(275);
    localparam int K_IB = kq(321);
    localparam int K_QR = kq(212);
    localparam int K_QG = kq(523);
    localparam int K_QB = kq(311);
    localparam int K_RI = kq(956);
    localparam int K_RQ = kq(621);
    localparam int K_GI = kq(272);
    localparam int K_GQ = kq(647);
    localparam int K_BI = kq(1106);
    localparam int K_BQ = kq(1703);

    localparam int COEF_W = COEF_FRAC_BITS + 1;      // unsigned coefficient magnitude
    localparam int PR_W   = COEF_W + CH_W;           // coefficient times channel
    localparam int SUM_W  = COEF_FRAC_BITS + 11;     // signed Y, I, Q at scale 2^F

    // Noise term: |noise| * level * 255 * 2^(F-8) / 1000, rounded half away.
    localparam int P_W     = NOISE_W + LEVEL_W;
    localparam int KN      = 255 << (COEF_FRAC_BITS - 8);
    localparam int KN_W    = $clog2(KN + 1);
    localparam int X_W     = P_W + KN_W;
    localparam int Y8_W    = X_W - 3;                // after the floor divide by 8
    localparam int DIV_S   = Y8_W + 7;               // divide by 125 via reciprocal
    localparam longint DIV_M = ((longint'(1) << DIV_S) + 124) / 125;
    localparam int DIV_M_W = DIV_S - 6;
    localparam int DIV_P_W = Y8_W + DIV_M_W;
    localparam int NT_W    = DIV_P_W - DIV_S;        // noise term magnitude

    localparam int YN_W   = ((SUM_W > NT_W + 1) ? SUM_W : NT_W + 1) + 1;
    localparam int MP_W   = SUM_W + COEF_W + 1;      // signed chroma product
    localparam int ACC_W  = YN_W + COEF_FRAC_BITS + 2;
    localparam int Q_W    = ACC_W - 1 - 2 * COEF_FRAC_BITS;
    localparam longint HALF = longint'(1) << (2 * COEF_FRAC_BITS - 1);

    typedef logic [PR_W-1:0]          t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [YN_W-1:0]   t_yn;
    typedef logic signed [MP_W-1:0]   t_mprod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [CH_W-1:0]          t_byte;

    // The accumulator already carries the rounding half. A negative value
    // rounds to zero or below and clips to zero.
    function automatic t_byte sat_byte(input t_acc acc);
        logic [Q_W-1:0] q;
        q = acc[ACC_W-2:2*COEF_FRAC_BITS];
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (q > Q_W'(255)) begin
            return 8'hFF;
        end else begin
            return q[CH_W-1:0];
        end
    endfunction

endpackage

### design/rgb_yiq_luma_noise_pixel_top.sv
// ============================================================================
// RGB/YIQ luma noise pixel pipeline
// Converts R8G8B8 pixels to NTSC YIQ, adds a scaled noise sample to luma and
// converts back to clipped R8G8B8, one pixel per clock when nothing stalls.
// ============================================================================
// The block takes one pixel and one noise sample per transfer on the slave
// stream and returns one pixel per transfer on the master stream, in order.
// It sustains one pixel per clock when the master side does not stall. It
// has seven register stages, each holding one pixel. Each stage moves on
// when it is empty or when the stage after it moves, so bubbles close up
// under back-pressure and the slave side keeps taking pixels until all
// seven stages are full. The luma noise term equals noise_milli/1000 *
// noise_level/256 * 255, with noise_level written through the APB port at
// byte address 0 (reset value zero, meaning no noise); write it only while
// no pixel is in flight.
// Stage plan: coefficient products and noise magnitude times level; Y, I and
// Q sums and the noise scaling; the divide by 125 as a reciprocal product;
// noisy luma; chroma products for the inverse transform; the three channel
// accumulators with the rounding half; then clipping into the output register.
module rgb_yiq_luma_noise_pixel_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: [7:0] red_in, [15:8] green_in, [23:16] blue_in,
    // [34:24] noise_milli, [39:35] zero.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,
    // Master stream: [7:0] red_out, [15:8] green_out, [23:16] blue_out.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ryln_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int F = ryln_pkg::COEF_FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [ryln_pkg::LEVEL_W-1:0] r_noise_level;
    logic                         cfg_wr;
    logic                         cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == ryln_pkg::ADDR_NOISE_LEVEL);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? 32'(r_noise_level) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_level <= '0;
        end else if (cfg_wr) begin
            r_noise_level <= pwdata[ryln_pkg::LEVEL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when its
    // contents move on to the next stage in the same cycle.
    // ------------------------------------------------------------------
    logic [7:1] r_vld;
    logic [7:1] n_vld;
    logic [8:1] stage_load;

    always_comb begin
        stage_load[8] = i_m_axis_tready;
        for (int k = 7; k >= 1; k--) begin
            stage_load[k] = !r_vld[k] || stage_load[k+1];
        end
        n_vld = (stage_load[7:1] & {r_vld[6:1], i_s_axis_tvalid})
              | (~stage_load[7:1] & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = stage_load[1];
    assign o_m_axis_tvalid = r_vld[7];

    // ------------------------------------------------------------------
    // Stage 1: forward coefficient products and |noise| * level.
    // ------------------------------------------------------------------
    logic [ryln_pkg::CH_W-1:0]    in_red, in_green, in_blue;
    logic [ryln_pkg::NOISE_W-1:0] in_noise;
    logic [ryln_pkg::NOISE_W-1:0] noise_mag;

    assign in_red   = i_s_axis_tdata[7:0];
    assign in_green = i_s_axis_tdata[15:8];
    assign in_blue  = i_s_axis_tdata[23:16];
    assign in_noise = i_s_axis_tdata[34:24];
    // The most negative sample maps to 1024, which still fits unsigned.
    assign noise_mag = in_noise[ryln_pkg::NOISE_W-1] ? (ryln_pkg::NOISE_W'(0) - in_noise)
                                                     : in_noise;

    ryln_pkg::t_prod r1_yr, r1_yg, r1_yb, r1_ir, r1_ig, r1_ib, r1_qr, r1_qg, r1_qb;
    logic [ryln_pkg::P_W-1:0] r1_p;
    logic                     r1_neg;

    always_ff @(posedge i_clk) begin
        if (stage_load[1]) begin
            r1_yr  <= ryln_pkg::PR_W'(ryln_pkg::K_YR) * ryln_pkg::PR_W'(in_red);
            r1_yg  <= ryln_pkg::PR_W'(ryln_pkg::K_YG) * ryln_pkg::PR_W'(in_green);
            r1_yb  <= ryln_pkg::PR_W'(ryln_pkg::K_YB) * ryln_pkg::PR_W'(in_blue);
            r1_ir  <= ryln_pkg::PR_W'(ryln_pkg::K_IR) * ryln_pkg::PR_W'(in_red);
            r1_ig  <= ryln_pkg::PR_W'(ryln_pkg::K_IG) * ryln_pkg::PR_W'(in_green);
            r1_ib  <= ryln_pkg::PR_W'(ryln_pkg::K_IB) * ryln_pkg::PR_W'(in_blue);
            r1_qr  <= ryln_pkg::PR_W'(ryln_pkg::K_QR) * ryln_pkg::PR_W'(in_red);
            r1_qg  <= ryln_pkg::PR_W'(ryln_pkg::K_QG) * ryln_pkg::PR_W'(in_green);
            r1_qb  <= ryln_pkg::PR_W'(ryln_pkg::K_QB) * ryln_pkg::PR_W'(in_blue);
            r1_p   <= ryln_pkg::P_W'(noise_mag) * ryln_pkg::P_W'(r_noise_level);
            r1_neg <= in_noise[ryln_pkg::NOISE_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Y, I, Q sums; noise magnitude scaled, rounding offset added
    // and divided by 8 (the first factor of 1000).
    // ------------------------------------------------------------------
    ryln_pkg::t_sum n2_y, n2_i, n2_q;
    logic [ryln_pkg::X_W-1:0] n2_x;

    always_comb begin
        n2_y = $signed(ryln_pkg::SUM_W'(r1_yr)) + $signed(ryln_pkg::SUM_W'(r1_yg))
             + $signed(ryln_pkg::SUM_W'(r1_yb));
        n2_i = $signed(ryln_pkg::SUM_W'(r1_ir)) - $signed(ryln_pkg::SUM_W'(r1_ig))
             - $signed(ryln_pkg::SUM_W'(r1_ib));
        n2_q = $signed(ryln_pkg::SUM_W'(r1_qr)) - $signed(ryln_pkg::SUM_W'(r1_qg))
             + $signed(ryln_pkg::SUM_W'(r1_qb));
        n2_x = ryln_pkg::X_W'(r1_p) * ryln_pkg::X_W'(ryln_pkg::KN) + ryln_pkg::X_W'(500);
    end

    ryln_pkg::t_sum            r2_y, r2_i, r2_q;
    logic [ryln_pkg::Y8_W-1:0] r2_y8;
    logic                      r2_neg;

    always_ff @(posedge i_clk) begin
        if (stage_load[2]) begin
            r2_y   <= n2_y;
            r2_i   <= n2_i;
            r2_q   <= n2_q;
            r2_y8  <= n2_x[ryln_pkg::X_W-1:3];
            r2_neg <= r1_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by 125 as an exact reciprocal product.
    // ------------------------------------------------------------------
    ryln_pkg::t_sum               r3_y, r3_i, r3_q;
    logic [ryln_pkg::DIV_P_W-1:0] r3_prod;
    logic                         r3_neg;

    always_ff @(posedge i_clk) begin
        if (stage_load[3]) begin
            r3_y    <= r2_y;
            r3_i    <= r2_i;
            r3_q    <= r2_q;
            r3_prod <= ryln_pkg::DIV_P_W'(r2_y8) * ryln_pkg::DIV_P_W'(ryln_pkg::DIV_M);
            r3_neg  <= r2_neg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: noisy luma.
    // ------------------------------------------------------------------
    ryln_pkg::t_yn n4_y_ext, n4_nt, n4_yn;

    always_comb begin
        n4_y_ext = ryln_pkg::YN_W'(r3_y);
        n4_nt    = $signed(ryln_pkg::YN_W'(r3_prod[ryln_pkg::DIV_P_W-1:ryln_pkg::DIV_S]));
        n4_yn    = r3_neg ? (n4_y_ext - n4_nt) : (n4_y_ext + n4_nt);
    end

    ryln_pkg::t_yn  r4_yn;
    ryln_pkg::t_sum r4_i, r4_q;

    always_ff @(posedge i_clk) begin
        if (stage_load[4]) begin
            r4_yn <= n4_yn;
            r4_i  <= r3_i;
            r4_q  <= r3_q;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: inverse-transform chroma products.
    // ------------------------------------------------------------------
    ryln_pkg::t_mprod n5_i, n5_q;
    ryln_pkg::t_mprod r5_ri, r5_rq, r5_gi, r5_gq, r5_bi, r5_bq;
    ryln_pkg::t_yn    r5_yn;

    assign n5_i = ryln_pkg::MP_W'(r4_i);
    assign n5_q = ryln_pkg::MP_W'(r4_q);

    always_ff @(posedge i_clk) begin
        if (stage_load[5]) begin
            r5_yn <= r4_yn;
            r5_ri <= n5_i * $signed(ryln_pkg::MP_W'(ryln_pkg::K_RI));
            r5_rq <= n5_q * $signed(ryln_pkg::MP_W'(ryln_pkg::K_RQ));
            r5_gi <= n5_i * $signed(ryln_pkg::MP_W'(ryln_pkg::K_GI));
            r5_gq <= n5_q * $signed(ryln_pkg::MP_W'(ryln_pkg::K_GQ));
            r5_bi <= n5_i * $signed(ryln_pkg::MP_W'(ryln_pkg::K_BI));
            r5_bq <= n5_q * $signed(ryln_pkg::MP_W'(ryln_pkg::K_BQ));
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: channel accumulators at scale 2^(2F), rounding half added.
    // ------------------------------------------------------------------
    ryln_pkg::t_acc n6_base, n6_r, n6_g, n6_b;

    always_comb begin
        n6_base = (ryln_pkg::ACC_W'(r5_yn) <<< F) + $signed(ryln_pkg::ACC_W'(ryln_pkg::HALF));
        n6_r    = n6_base + ryln_pkg::ACC_W'(r5_ri) + ryln_pkg::ACC_W'(r5_rq);
        n6_g    = n6_base - ryln_pkg::ACC_W'(r5_gi) - ryln_pkg::ACC_W'(r5_gq);
        n6_b    = n6_base - ryln_pkg::ACC_W'(r5_bi) + ryln_pkg::ACC_W'(r5_bq);
    end

    ryln_pkg::t_acc r6_acc_r, r6_acc_g, r6_acc_b;

    always_ff @(posedge i_clk) begin
        if (stage_load[6]) begin
            r6_acc_r <= n6_r;
            r6_acc_g <= n6_g;
            r6_acc_b <= n6_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round, clip and hold for the master-side transfer.
    // ------------------------------------------------------------------
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (stage_load[7]) begin
            r_out_data <= {ryln_pkg::sat_byte(r6_acc_b),
                           ryln_pkg::sat_byte(r6_acc_g),
                           ryln_pkg::sat_byte(r6_acc_r)};
        end
    end

    assign o_m_axis_tdata = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // With every stage full and the master side stalled, no pixel may enter.
    a_full_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_axis_tready) |-> !o_s_axis_tready
    ) else $error("pixel accepted while pipeline full and stalled");

    // A negative red accumulator must clip to zero in the output register.
    a_red_clips_low: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && stage_load[7] && r6_acc_r[ryln_pkg::ACC_W-1])
            |=> (o_m_axis_tdata[7:0] == 8'd0)
    ) else $error("negative red sum did not clip to zero");

    // Reset empties the pipeline.
    a_reset_empties: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (r_vld == '0) && !o_m_axis_tvalid
    ) else $error("pipeline not empty after reset");

    // The output valid bit only changes when stage 7 loads.
    a_out_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !stage_load[7] |=> $stable(r_vld[7]) && $stable(r_out_data)
    ) else $error("output stage changed without a load");

endmodule

### bench/tb_rgb_yiq_luma_noise_pixel_top.sv
// ============================================================================
// Testbench for the RGB/YIQ luma noise pixel pipeline
// Streams pixels with noise samples into the block under several noise
// levels and idle patterns. Each output pixel is checked against a
// fixed-point model of the YIQ round trip that is kept in the testbench.
// ============================================================================
module tb_rgb_yiq_luma_noise_pixel_top;

    localparam int FRAC    = ryln_pkg::COEF_FRAC_BITS;
    localparam int CH_W    = ryln_pkg::CH_W;
    localparam int NOISE_W = ryln_pkg::NOISE_W;
    localparam int LEVEL_W = ryln_pkg::LEVEL_W;

    // One input transfer on the slave stream, red in the lowest bits.
    typedef struct packed {
        logic signed [NOISE_W-1:0] noise;
        logic [CH_W-1:0]           blue;
        logic [CH_W-1:0]           green;
        logic [CH_W-1:0]           red;
    } t_rgbn;

    // One output transfer on the master stream.
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [34:24] noise_milli,
    // [39:35] zero.
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out.
    logic [23:0] o_m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ryln_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgb_yiq_luma_noise_pixel_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Pixels waiting to be driven, and output pixels predicted for the
    // transfers the block has already taken, oldest first.
    t_rgbn pixel_pending_q[$];
    t_rgb  rgb_predicted_q[$];

    logic [LEVEL_W-1:0] noise_level_now;  // our copy of the noise level register
    int unsigned pixels_queued;
    int unsigned pixels_taken;
    int unsigned error_count;
    int unsigned src_idle_pct;   // chance in percent that the source holds back
    int unsigned sink_stall_pct; // chance in percent that the sink drops tready
    logic        s_taken;        // the slave side took a transfer at the last edge

    // ------------------------------------------------------------------------
    // Clock: period of 10 time units.
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Prediction. Coefficients are thousandths rounded half up to Q2.F, the
    // YIQ sums are exact, the noise term is rounded half away from zero to
    // scale 2^F, and each channel sum at scale 2^(2F) is rounded half away
    // from zero before it is clipped to a byte.
    // ------------------------------------------------------------------------
    function automatic longint coef_q(input int milli);
        return (longint'(milli) * (longint'(1) << FRAC) + 500) / 1000;
    endfunction

    function automatic longint div_half_away(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (mag + den / 2) / den;
        return (num < 0) ? -quo : quo;
    endfunction

    function automatic logic [CH_W-1:0] clip_channel(input longint acc);
        longint v;
        v = div_half_away(acc, longint'(1) << (2 * FRAC));
        if (v < 0) begin
            return '0;
        end else if (v > 255) begin
            return 8'hFF;
        end
        return v[CH_W-1:0];
    endfunction

    function automatic t_rgb yiq_noise_round_trip(input t_rgbn px,
                                                  input logic [LEVEL_W-1:0] lvl);
        longint r, g, b, nz, y, ci, cq, nterm, yn;
        t_rgb   res;
        r  = longint'(px.red);
        g  = longint'(px.green);
        b  = longint'(px.blue);
        nz = longint'($signed(px.noise));
        y  = coef_q(299) * r + coef_q(587) * g + coef_q(114) * b;
        ci = coef_q(596) * r - coef_q(275) * g - coef_q(321) * b;
        cq = coef_q(212) * r - coef_q(523) * g + coef_q(311) * b;
        nterm = div_half_away(nz * longint'(lvl) * 255 * (longint'(1) << FRAC), 256000);
        yn = (y + nterm) * (longint'(1) << FRAC);
        res.red   = clip_channel(yn + coef_q(956) * ci + coef_q(621) * cq);
        res.green = clip_channel(yn - coef_q(272) * ci - coef_q(647) * cq);
        res.blue  = clip_channel(yn - coef_q(1106) * ci + coef_q(1703) * cq);
        return res;
    endfunction

    task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Source driver. It moves on to the next pixel only once the current one
    // has been taken, and otherwise holds tvalid and tdata steady.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !s_taken) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (pixel_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            i_s_axis_tdata  <= {5'b0, pixel_pending_q.pop_front()};
            i_s_axis_tvalid <= 1'b1;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: tready drops at random as the current stall rate asks.
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor. An output transfer is checked before an input transfer of the
    // same edge is predicted, so the order of the store is never disturbed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        s_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (rgb_predicted_q.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual %h",
                             $time, got);
                    error_count++;
                end else begin
                    want = rgb_predicted_q.pop_front();
                    check_channel("red", want.red, got.red);
                    check_channel("green", want.green, got.green);
                    check_channel("blue", want.blue, got.blue);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rgb_predicted_q.push_back(
                    yiq_noise_round_trip(t_rgbn'(i_s_axis_tdata[34:0]), noise_level_now));
                pixels_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic add_pixel(input int r, input int g, input int b, input int nz);
        t_rgbn px;
        px.red   = r[CH_W-1:0];
        px.green = g[CH_W-1:0];
        px.blue  = b[CH_W-1:0];
        px.noise = nz[NOISE_W-1:0];
        pixel_pending_q.push_back(px);
        pixels_queued++;
    endtask

    // Most noise samples stay in the nominal -1000..1000 range; one in ten
    // takes any 11-bit pattern so the out-of-range codes are covered too.
    task automatic add_random_pixels(input int count);
        int nz;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9) == 0) begin
                nz = $urandom_range(2047);
            end else begin
                nz = int'($urandom_range(2000)) - 1000;
            end
            add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), nz);
        end
    endtask

    // Blocks until every queued pixel has been taken and every predicted
    // output has come back; the source keeps driving queued pixels meanwhile.
    task automatic wait_for_drain();
        while (pixels_taken != pixels_queued || rgb_predicted_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the rising edge that ends the access cycle.
    task automatic write_noise_level(input int lvl);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ryln_pkg::ADDR_NOISE_LEVEL;
        pwdata  <= 32'(lvl[LEVEL_W-1:0]);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        noise_level_now = lvl[LEVEL_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        int levels[6];
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        s_taken         = 1'b0;
        noise_level_now = '0;
        pixels_queued   = 0;
        pixels_taken    = 0;
        error_count     = 0;
        // First pattern: the source is mostly busy and the sink mostly stalls.
        src_idle_pct    = 10;
        sink_stall_pct  = 85;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The level is still zero after reset, so noise must have no effect.
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 1000);
        add_pixel(128, 64, 32, -1000);
        wait_for_drain();

        // Full scale noise: black and white pushed past both clip limits,
        // the primaries and secondaries, and small values near zero.
        write_noise_level(256);
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(0, 0, 0, 1000);
        add_pixel(0, 0, 0, -1000);
        add_pixel(255, 255, 255, 1000);
        add_pixel(255, 255, 255, -1000);
        add_pixel(0, 0, 0, 1023);
        add_pixel(255, 255, 255, -1024);
        add_pixel(255, 0, 0, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(0, 0, 255, 0);
        add_pixel(255, 255, 0, 0);
        add_pixel(0, 255, 255, 0);
        add_pixel(255, 0, 255, 0);
        add_pixel(128, 128, 128, 500);
        add_pixel(128, 128, 128, -500);
        add_pixel(1, 2, 3, 1);
        add_pixel(254, 253, 252, -1);
        wait_for_drain();

        // Gain above one, with the extreme noise codes on mid gray.
        write_noise_level(511);
        add_pixel(128, 128, 128, 1023);
        add_pixel(128, 128, 128, -1024);
        wait_for_drain();

        // Random part: six settings of the noise level, two for each idle
        // pattern. Each segment drains fully before the next write.
        levels = '{511, 0, 1, 256, 0, 128};
        levels[4] = $urandom_range(511);
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                src_idle_pct   = 85;
                sink_stall_pct = 10;
            end else if (seg == 4) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            write_noise_level(levels[seg]);
            add_random_pixels(75);
            wait_for_drain();
        end

        // Let the pipeline run on for a while so that any stray output shows.
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
design/ryln_pkg.sv
design/rgb_yiq_luma_noise_pixel_top.sv
bench/tb_rgb_yiq_luma_noise_pixel_top.sv
